>>> rtl/i2u8rq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// i2u8rq_pkg
// Shared types and constants of the int32 to uint8 requantizer.
// ============================================================================
package i2u8rq_pkg;

    localparam int ACC_W    = 32;
    localparam int SCALE_W  = 30;
    localparam int MANT_W   = 23;
    localparam int EXP_W    = 7;
    localparam int MULT_W   = MANT_W + 1;
    localparam int PROD_W   = ACC_W + MULT_W;
    localparam int SHIFT_W  = 5;
    localparam int ROUND_W  = ACC_W + 1;
    localparam int OUT_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [EXP_W-1:0] EXP_NO_SHIFT = 7'd126;
    localparam logic [EXP_W-1:0] EXP_MIN_SHIFT = 7'd95;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 30'h3F00_0000;
    localparam logic [OUT_W-1:0]   OUT_MAX     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_BITS  = 2'd0,
        CFG_ZERO_OFFSET = 2'd1,
        CFG_CLAMP_LOW   = 2'd2,
        CFG_CLAMP_HIGH  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHIFT_PASS,
        SHIFT_ROUND,
        SHIFT_ZERO
    } t_shift_mode;

    typedef struct packed {
        logic [OUT_W-1:0] zero_offset;
        logic [OUT_W-1:0] clamp_low;
        logic [OUT_W-1:0] clamp_high;
    } t_clamp_cfg;

endpackage

>>> rtl/i2u8rq_clamp.sv
`timescale 1ns / 1ps
// ============================================================================
// i2u8rq_clamp
// Adds the zero point to the rounded value, limits it to the output range and then to the clamp bounds.
// ============================================================================
module i2u8rq_clamp (
    input  logic signed [i2u8rq_pkg::ROUND_W-1:0] i_value,
    input  i2u8rq_pkg::t_clamp_cfg                i_cfg,
    output logic        [i2u8rq_pkg::OUT_W-1:0]   o_value
);

    logic signed [i2u8rq_pkg::ROUND_W:0] sum;
    logic        [i2u8rq_pkg::OUT_W-1:0] sat;
    logic        [i2u8rq_pkg::OUT_W-1:0] upper;

    always_comb begin
        sum = {i_value[i2u8rq_pkg::ROUND_W-1], i_value}
            + $signed({{(i2u8rq_pkg::ROUND_W + 1 - i2u8rq_pkg::OUT_W){1'b0}},
                       i_cfg.zero_offset});
        if (sum < 0) begin
            sat = '0;
        end else if (sum > $signed({{(i2u8rq_pkg::ROUND_W + 1 - i2u8rq_pkg::OUT_W){1'b0}},
                                    i2u8rq_pkg::OUT_MAX})) begin
            sat = i2u8rq_pkg::OUT_MAX;
        end else begin
            sat = sum[i2u8rq_pkg::OUT_W-1:0];
        end
        upper   = (sat > i_cfg.clamp_high) ? i_cfg.clamp_high : sat;
        o_value = (upper < i_cfg.clamp_low) ? i_cfg.clamp_low : upper;
    end

endmodule

>>> rtl/int32_to_uint8_requantizer.sv
`timescale 1ns / 1ps
// ============================================================================
// int32_to_uint8_requantizer
// Scales signed 32-bit accumulators to clamped unsigned 8-bit values.
// ============================================================================
// The input channel (i_valid, o_ready) takes one word per cycle while o_ready
// is high: a signed accumulator and its last flag. The output channel (o_valid,
// i_ready) gives the requantized byte with the flag copied through, in input order.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the scale bit
// pattern, zero point and clamp bounds; it is always ready. The user must write
// it only while no word is in flight; the block itself does not enforce this.
// From acceptance to o_valid a word passes an input register, a 32 x 24 bit
// multiply stage, a rounding shift stage and the zero point and clamp stage
// feeding the output register. Throughput is one word per cycle unless stalled.
// Each stage holds its word when the stage after it is full and not moving,
// so a stalled receiver backs the pipeline up one stage at a time and no
// word is lost or repeated.
// Reset empties the pipeline and loads a scale of 0.5, zero point 0 and
// clamp bounds 0 and 255.
// ============================================================================
module int32_to_uint8_requantizer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [i2u8rq_pkg::ACC_W-1:0]           i_accum,
    input  logic                                   i_last_in,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [i2u8rq_pkg::OUT_W-1:0]           o_quantized,
    output logic                                   o_last_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [i2u8rq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [i2u8rq_pkg::SCALE_W-1:0]         i_cfg_data
);

    logic [i2u8rq_pkg::SCALE_W-1:0] r_scale;
    i2u8rq_pkg::t_clamp_cfg         r_clamp;

    logic                                  r_v1, r_v2, r_v3, r_v4;
    logic                                  r_l1, r_l2, r_l3, r_l4;
    logic signed [i2u8rq_pkg::ACC_W-1:0]   r_acc;
    logic signed [i2u8rq_pkg::PROD_W-1:0]  r_prod;
    logic signed [i2u8rq_pkg::ROUND_W-1:0] r_round;
    logic        [i2u8rq_pkg::OUT_W-1:0]   r_quant;

    logic                                  adv1, adv2, adv3, adv4;
    logic        [i2u8rq_pkg::EXP_W-1:0]   exponent;
    logic signed [i2u8rq_pkg::MULT_W:0]    mult;
    logic signed [i2u8rq_pkg::PROD_W:0]    product;
    i2u8rq_pkg::t_shift_mode               shift_mode;
    logic        [i2u8rq_pkg::SHIFT_W-1:0] shift;
    logic signed [i2u8rq_pkg::ROUND_W-1:0] q_ext;
    logic signed [i2u8rq_pkg::ROUND_W-1:0] half;
    logic signed [i2u8rq_pkg::ROUND_W-1:0] n_round;
    logic        [i2u8rq_pkg::OUT_W-1:0]   n_quant;

    assign o_cfg_ready = 1'b1;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    assign exponent = r_scale[i2u8rq_pkg::SCALE_W-1:i2u8rq_pkg::MANT_W];
    assign mult     = $signed({2'b01, r_scale[i2u8rq_pkg::MANT_W-1:0]});
    assign product  = r_acc * mult;

    always_comb begin
        shift = i2u8rq_pkg::SHIFT_W'(i2u8rq_pkg::EXP_NO_SHIFT - exponent);
        if (exponent >= i2u8rq_pkg::EXP_NO_SHIFT) begin
            shift_mode = i2u8rq_pkg::SHIFT_PASS;
        end else if (exponent < i2u8rq_pkg::EXP_MIN_SHIFT) begin
            shift_mode = i2u8rq_pkg::SHIFT_ZERO;
        end else begin
            shift_mode = i2u8rq_pkg::SHIFT_ROUND;
        end
        q_ext = {r_prod[i2u8rq_pkg::PROD_W-1],
                 r_prod[i2u8rq_pkg::PROD_W-1:i2u8rq_pkg::MULT_W]};
        half  = $signed(i2u8rq_pkg::ROUND_W'(1) << (shift - 1'b1));
        case (shift_mode)
            i2u8rq_pkg::SHIFT_PASS:  n_round = q_ext;
            i2u8rq_pkg::SHIFT_ROUND: n_round = (q_ext + half) >>> shift;
            i2u8rq_pkg::SHIFT_ZERO:  n_round = '0;
            default:                 n_round = '0;
        endcase
    end

    i2u8rq_clamp u_clamp (
        .i_value (r_round),
        .i_cfg   (r_clamp),
        .o_value (n_quant)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale            <= i2u8rq_pkg::SCALE_RESET;
            r_clamp.zero_offset <= '0;
            r_clamp.clamp_low  <= '0;
            r_clamp.clamp_high <= i2u8rq_pkg::OUT_MAX;
        end else if (i_cfg_valid) begin
            case (i2u8rq_pkg::t_cfg_idx'(i_cfg_index))
                i2u8rq_pkg::CFG_SCALE_BITS:  r_scale <= i_cfg_data;
                i2u8rq_pkg::CFG_ZERO_OFFSET:
                    r_clamp.zero_offset <= i_cfg_data[i2u8rq_pkg::OUT_W-1:0];
                i2u8rq_pkg::CFG_CLAMP_LOW:
                    r_clamp.clamp_low <= i_cfg_data[i2u8rq_pkg::OUT_W-1:0];
                i2u8rq_pkg::CFG_CLAMP_HIGH:
                    r_clamp.clamp_high <= i_cfg_data[i2u8rq_pkg::OUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_acc <= $signed(i_accum);
            r_l1  <= i_last_in;
        end
        if (adv2) begin
            r_prod <= product[i2u8rq_pkg::PROD_W-1:0];
            r_l2   <= r_l1;
        end
        if (adv3) begin
            r_round <= n_round;
            r_l3    <= r_l2;
        end
        if (adv4) begin
            r_quant <= n_quant;
            r_l4    <= r_l3;
        end
    end

    assign o_valid     = r_v4;
    assign o_quantized = r_quant;
    assign o_last_out  = r_l4;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the int32 to uint8 requantizer.
// ============================================================================
// Accumulator words are driven through the valid/ready input channel and
// every accepted word is run through a behavioral requantizer that tracks
// the current scale, zero point and clamp bounds. The predicted bytes are
// queued and compared field by field with the words that leave the output
// channel. Directed tests cover the field extremes, rounding of halves, the
// scale and clamp corner cases and a stalled receiver; random phases with
// fresh register settings follow. Both channels idle at random outside the gap-free parts.
// ============================================================================
module tb_top;

    typedef struct {
        logic [i2u8rq_pkg::OUT_W-1:0] quantized;
        logic                         last_out;
        logic [i2u8rq_pkg::ACC_W-1:0] accum;
    } t_byte_word;

    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_HALF    = 30'h3F00_0000;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_QUARTER = 30'h3E80_0000;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_ONE     = 30'h3F80_0000;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_TOP     = 30'h3FFF_FFFF;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_MIN     = 30'h2F80_0000;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_TINY    = 30'h2F00_0000;
    localparam logic [i2u8rq_pkg::SCALE_W-1:0] SCALE_NONE    = 30'h0000_0000;
    localparam logic [i2u8rq_pkg::ACC_W-1:0]   ACC_MAX       = 32'h7FFF_FFFF;
    localparam logic [i2u8rq_pkg::ACC_W-1:0]   ACC_MIN       = 32'h8000_0000;

    logic                                 i_clk;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_ready;
    logic [i2u8rq_pkg::ACC_W-1:0]         i_accum     = '0;
    logic                                 i_last_in   = 1'b0;
    logic                                 o_valid;
    logic                                 i_ready     = 1'b0;
    logic [i2u8rq_pkg::OUT_W-1:0]         o_quantized;
    logic                                 o_last_out;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [i2u8rq_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [i2u8rq_pkg::SCALE_W-1:0]       i_cfg_data  = '0;

    logic [i2u8rq_pkg::SCALE_W-1:0] cur_scale;
    logic [i2u8rq_pkg::OUT_W-1:0]   cur_zero;
    logic [i2u8rq_pkg::OUT_W-1:0]   cur_lo;
    logic [i2u8rq_pkg::OUT_W-1:0]   cur_hi;

    t_byte_word pending_bytes[$];
    int         err_cnt    = 0;
    int         sink_hold  = 0;
    bit         src_gaps   = 1'b1;
    bit         sink_gaps  = 1'b1;

    int32_to_uint8_requantizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_accum     (i_accum),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quantized (o_quantized),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [i2u8rq_pkg::OUT_W-1:0] requant_byte(
        input logic [i2u8rq_pkg::ACC_W-1:0] acc
    );
        longint mult;
        longint scaled;
        longint rounded;
        longint v;
        int     rshift;
        mult    = {40'd0, 1'b1, cur_scale[i2u8rq_pkg::MANT_W-1:0]};
        mult    = mult << 7;
        scaled  = (longint'($signed(acc)) * mult) >>> 31;
        rshift  = 126 - int'(cur_scale[i2u8rq_pkg::SCALE_W-1:i2u8rq_pkg::MANT_W]);
        if (rshift <= 0) begin
            rounded = scaled;
        end else if (rshift >= 32) begin
            rounded = 0;
        end else begin
            rounded = (scaled + (longint'(1) << (rshift - 1))) >>> rshift;
        end
        v = rounded;
        if (v < -32768) v = -32768;
        if (v > 32767)  v = 32767;
        v = v + longint'(cur_zero);
        if (v > 32767)  v = 32767;
        if (v < 0)      v = 0;
        if (v > 255)    v = 255;
        if (v > longint'(cur_hi)) v = longint'(cur_hi);
        if (v < longint'(cur_lo)) v = longint'(cur_lo);
        return v[i2u8rq_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : sink_side
        t_byte_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected word quantized=%0d last=%0b",
                                          o_quantized, o_last_out));
            end else begin
                want = pending_bytes.pop_front();
                if (o_quantized !== want.quantized)
                    report_mismatch($sformatf("accum %0d: quantized %0d, expected %0d",
                                              $signed(want.accum), o_quantized,
                                              want.quantized));
                if (o_last_out !== want.last_out)
                    report_mismatch($sformatf("accum %0d: last %0b, expected %0b",
                                              $signed(want.accum), o_last_out,
                                              want.last_out));
            end
        end
        if (sink_hold > 0) sink_hold--;
        i_ready <= (sink_hold == 0) && !(sink_gaps && $urandom_range(0, 99) < 10);
    end

    task automatic send_word(input logic [i2u8rq_pkg::ACC_W-1:0] acc, input logic lst);
        t_byte_word w;
        while (src_gaps && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accum   <= acc;
        i_last_in <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        w.quantized = requant_byte(acc);
        w.last_out  = lst;
        w.accum     = acc;
        pending_bytes.push_back(w);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input i2u8rq_pkg::t_cfg_idx idx,
                             input logic [i2u8rq_pkg::SCALE_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            i2u8rq_pkg::CFG_SCALE_BITS:  cur_scale = data;
            i2u8rq_pkg::CFG_ZERO_OFFSET: cur_zero  = data[i2u8rq_pkg::OUT_W-1:0];
            i2u8rq_pkg::CFG_CLAMP_LOW:   cur_lo    = data[i2u8rq_pkg::OUT_W-1:0];
            i2u8rq_pkg::CFG_CLAMP_HIGH:  cur_hi    = data[i2u8rq_pkg::OUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_byte(input i2u8rq_pkg::t_cfg_idx idx,
                            input logic [i2u8rq_pkg::OUT_W-1:0] val);
        cfg_write(idx, {22'($urandom), val});
    endtask

    function automatic logic [i2u8rq_pkg::ACC_W-1:0] random_accum();
        logic [i2u8rq_pkg::ACC_W-1:0] a;
        case ($urandom_range(0, 4))
            0: a = $urandom;
            1: a = $signed($urandom) >>> $urandom_range(0, 31);
            2: a = $signed($urandom) >>> $urandom_range(8, 24);
            3: a = $signed($urandom) >>> $urandom_range(20, 31);
            default: begin
                case ($urandom_range(0, 4))
                    0: a = ACC_MAX;
                    1: a = ACC_MIN;
                    2: a = '0;
                    3: a = 32'd1;
                    default: a = '1;
                endcase
            end
        endcase
        return a;
    endfunction

    task automatic test_reset_values();
        send_word(32'd0, 1'b0);
        send_word(32'd1, 1'b1);
        send_word('1, 1'b0);
        send_word(32'd3, 1'b1);
        send_word(32'd511, 1'b0);
        send_word(32'd512, 1'b1);
        send_word(ACC_MAX, 1'b0);
        send_word(ACC_MIN, 1'b1);
    endtask

    task automatic test_rounding();
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_QUARTER);
        send_word(32'd2, 1'b0);
        send_word(-32'sd2, 1'b1);
        send_word(32'd6, 1'b0);
        send_word(-32'sd6, 1'b1);
    endtask

    task automatic test_scale_corners();
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_ONE);
        send_word(32'd200, 1'b0);
        send_word(ACC_MAX, 1'b1);
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_TINY);
        send_word(ACC_MAX, 1'b0);
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_NONE);
        send_word(ACC_MIN, 1'b1);
    endtask

    task automatic test_offset_and_clamps();
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_TOP);
        cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'd255);
        send_word(ACC_MAX, 1'b0);
        send_word(ACC_MIN, 1'b1);
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_HALF);
        cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'd128);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, 8'd10);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, 8'd100);
        send_word(-32'sd300, 1'b0);
        send_word(32'd300, 1'b1);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, 8'd200);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, 8'd50);
        send_word(32'd0, 1'b0);
        send_word(ACC_MAX, 1'b1);
    endtask

    task automatic test_backpressure();
        cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_MIN + 30'h0A80_0000);
        cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'd64);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, 8'd0);
        cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, 8'd255);
        src_gaps  = 1'b0;
        sink_hold = 80;
        repeat (40) send_word(random_accum(), 1'($urandom));
        src_gaps = 1'b1;
        repeat (8) send_word(random_accum(), 1'($urandom));
        wait_drained();
        repeat (8) send_word(random_accum(), 1'($urandom));
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [6:0]                   exp_field;
        logic [i2u8rq_pkg::OUT_W-1:0] a;
        logic [i2u8rq_pkg::OUT_W-1:0] b;
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: begin
                    cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_TOP);
                    cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'd255);
                    cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, 8'd0);
                    cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, 8'd255);
                end
                1: begin
                    cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, SCALE_MIN);
                    cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'd0);
                    cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, 8'd255);
                    cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, 8'd255);
                end
                default: begin
                    exp_field = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                            : 7'($urandom_range(100, 127));
                    cfg_write(i2u8rq_pkg::CFG_SCALE_BITS, {exp_field, 23'($urandom)});
                    cfg_byte(i2u8rq_pkg::CFG_ZERO_OFFSET, 8'($urandom));
                    a = 8'($urandom);
                    b = 8'($urandom);
                    if ((a > b) == ($urandom_range(0, 4) != 0)) begin
                        cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, b);
                        cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, a);
                    end else begin
                        cfg_byte(i2u8rq_pkg::CFG_CLAMP_LOW, a);
                        cfg_byte(i2u8rq_pkg::CFG_CLAMP_HIGH, b);
                    end
                end
            endcase
            src_gaps  = (p != 4);
            sink_gaps = (p != 4);
            repeat (per_phase) send_word(random_accum(), 1'($urandom));
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial begin
        cur_scale = i2u8rq_pkg::SCALE_RESET;
        cur_zero  = '0;
        cur_lo    = '0;
        cur_hi    = i2u8rq_pkg::OUT_MAX;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_rounding();
        test_scale_corners();
        test_offset_and_clamps();
        test_backpressure();
        test_random_phases(8, 55);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
